// ===== src/rt_pkg.sv =====
`default_nettype none

package rt_pkg;

    // default configuration
    localparam int MAX_COUNT_DEF  = 64;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field widths
    localparam int IN_BITS   = 32;
    localparam int RANK_BITS = 7;

    // input item
    typedef struct packed {
        logic signed [IN_BITS-1:0] value;
        logic                      last_value;
    } t_in;

    // result item
    typedef struct packed {
        logic [RANK_BITS-1:0] rank;
        logic                 last_rank;
        logic                 overflow;
    } t_out;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // store the accepted item
        logic cmp;    // compare candidate against the store
        logic grp;    // per-group population counts
        logic tot;    // final sum, emit rank, rotate store
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic final_rank;   // the rank being finished is the last of the set
    } t_stat;

endpackage

`default_nettype wire

// ===== src/rank_transform.sv =====
// Unmarked item: stored (overflow flagged when full), busy stays low, a new item may follow at once.
// Marked item: stored, then busy goes high and the stored items are ranked one by one,
// each through compare, group count and final sum; busy is high until the last final sum.
// Each rank is on o_out for one cycle under o_strobe; the receiver cannot stall.
// Synchronous active-low reset clears the element count, remaining count, overflow flag, strobe and controller.
`default_nettype none

module rank_transform #(
    parameter int MAX_COUNT  = rt_pkg::MAX_COUNT_DEF,
    parameter int VALUE_BITS = rt_pkg::VALUE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire rt_pkg::t_in i_in,
    output logic             busy,
    output rt_pkg::t_out     o_out,
    output logic             o_strobe
);
    import rt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    rt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mark  (i_in.last_value),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // store, comparators and counters
    rt_datapath #(
        .MAX_COUNT  (MAX_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_in     (i_in),
        .o_stat   (stat),
        .o_out    (o_out),
        .o_strobe (o_strobe)
    );

endmodule

`default_nettype wire

// ===== src/rt_ctrl.sv =====
`default_nettype none

module rt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_mark,
    input  wire rt_pkg::t_stat i_stat,
    output rt_pkg::t_cmd       o_cmd,
    output logic               busy
);
    import rt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_GRP  = 2'd2;
    localparam logic [1:0] ST_TOT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_mark) begin
                        n_state = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_GRP;
            end
            ST_GRP: begin
                o_cmd.grp = 1'b1;
                n_state   = ST_TOT;
            end
            ST_TOT: begin
                o_cmd.tot = 1'b1;
                n_state   = i_stat.final_rank ? ST_IDLE : ST_CMP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== src/rt_datapath.sv =====
`default_nettype none

module rt_datapath #(
    parameter int MAX_COUNT  = rt_pkg::MAX_COUNT_DEF,
    parameter int VALUE_BITS = rt_pkg::VALUE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire rt_pkg::t_cmd i_cmd,
    input  wire rt_pkg::t_in  i_in,
    output rt_pkg::t_stat     o_stat,
    output rt_pkg::t_out      o_out,
    output logic              o_strobe
);
    import rt_pkg::*;

    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int IDX_W  = $clog2(MAX_COUNT);
    localparam int GRP_SZ = 8;
    localparam int GRP_N  = (MAX_COUNT + GRP_SZ - 1) / GRP_SZ;
    localparam int GS_W   = $clog2(GRP_SZ + 1);

    // store: one key per cell, rotated as a ring while ranking
    logic [VALUE_BITS-1:0] r_cells [MAX_COUNT];
    logic [MAX_COUNT-1:0]  r_mask;     // cells that belong to the set
    logic [MAX_COUNT-1:0]  r_flags;    // cell smaller than candidate
    logic [GS_W-1:0]       r_grp [GRP_N];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_left;
    logic                  r_ovf;
    logic [CNT_W-1:0]      r_rank;
    logic                  r_last;
    logic                  r_ovf_out;
    logic                  r_strobe;

    logic signed [VALUE_BITS-1:0] value_ext;
    logic [VALUE_BITS-1:0]        key;
    logic                         full;
    logic [CNT_W-1:0]             n_size;
    logic [MAX_COUNT-1:0]         n_flags;
    logic [GS_W-1:0]              n_grp [GRP_N];
    logic [CNT_W-1:0]             n_total;

    // order-preserving key: two's complement with the sign bit flipped
    assign value_ext = VALUE_BITS'(i_in.value);
    assign key       = {~value_ext[VALUE_BITS-1], value_ext[VALUE_BITS-2:0]};
    assign full      = (r_count == CNT_W'(MAX_COUNT));
    assign n_size    = full ? r_count : r_count + CNT_W'(1);

    // compare every set member against the candidate in cell 0
    always_comb begin
        for (int j = 0; j < MAX_COUNT; j++) begin
            n_flags[j] = r_mask[j] && (r_cells[j] < r_cells[0]);
        end
    end

    // population count per group of eight flags
    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_SZ; b++) begin
                if (g * GRP_SZ + b < MAX_COUNT) begin
                    n_grp[g] = n_grp[g] + GS_W'(r_flags[g * GRP_SZ + b]);
                end
            end
        end
    end

    // sum of group counts
    always_comb begin
        n_total = '0;
        for (int g = 0; g < GRP_N; g++) begin
            n_total = n_total + CNT_W'(r_grp[g]);
        end
    end

    // store writes and ring rotation
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_cells[r_count[IDX_W-1:0]] <= key;
        end else if (i_cmd.tot) begin
            for (int k = 0; k < MAX_COUNT - 1; k++) begin
                r_cells[k] <= r_cells[k + 1];
            end
            r_cells[MAX_COUNT-1] <= r_cells[0];
        end
    end

    // set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_left  <= '0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_in.last_value) begin
                r_left <= n_size;
            end
        end else if (i_cmd.tot) begin
            r_left <= r_left - CNT_W'(1);
            if (o_stat.final_rank) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // membership mask, set up at the mark and rotated with the cells
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_in.last_value) begin
            for (int k = 0; k < MAX_COUNT; k++) begin
                r_mask[k] <= (CNT_W'(k) < n_size);
            end
        end else if (i_cmd.tot) begin
            r_mask <= {r_mask[0], r_mask[MAX_COUNT-1:1]};
        end
    end

    // compare and count pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp) begin
            r_flags <= n_flags;
        end
        if (i_cmd.grp) begin
            for (int g = 0; g < GRP_N; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.tot) begin
            r_rank    <= n_total + CNT_W'(1);
            r_last    <= o_stat.final_rank;
            r_ovf_out <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.tot;
        end
    end

    assign o_stat.final_rank = (r_left == CNT_W'(1));
    assign o_out.rank        = RANK_BITS'(r_rank);
    assign o_out.last_rank   = r_last;
    assign o_out.overflow    = r_ovf_out;
    assign o_strobe          = r_strobe;

endmodule

`default_nettype wire
